/* rtl/lpe_pkg.sv */
// Shared types and constants for the IPv4 L4 payload extractor.
// No dependencies; the other rtl files except lpe_fifo refer to this package by scoped names.
`timescale 1ns / 1ps

package lpe_pkg;

  // Input operation codes.
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Frame layout and protocol codes.
  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_TYPE_VLAN = 16'h8100;
  localparam logic [15:0] OFF_ETYPE_HI  = 16'd12;
  localparam logic [15:0] OFF_ETYPE_LO  = 16'd13;
  localparam logic [15:0] OFF_INNER_HI  = 16'd16;
  localparam logic [15:0] OFF_INNER_LO  = 16'd17;
  localparam logic [15:0] OFF_LAST      = 16'hFFFF;
  localparam logic [4:0]  IP_START_PLAIN = 5'd14;
  localparam logic [4:0]  IP_START_VLAN  = 5'd18;

  localparam logic [15:0] REL_VER_IHL   = 16'd0;
  localparam logic [15:0] REL_TLEN_HI   = 16'd2;
  localparam logic [15:0] REL_TLEN_LO   = 16'd3;
  localparam logic [15:0] REL_PROTO     = 16'd9;
  localparam logic [15:0] REL_TCP_DOFF  = 16'd12;

  localparam logic [3:0]  IP_VERSION4   = 4'd4;
  localparam logic [3:0]  MIN_WORDS     = 4'd5;
  localparam logic [5:0]  MIN_IP_HDR    = 6'd20;
  localparam logic [6:0]  UDP_HDR_BYTES = 7'd8;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;

  localparam logic [16:0] QUOTA_RESET   = 17'd1024;

  // Queue depths.
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  // Entry passed from the parser to the quota stage.
  typedef struct packed {
    logic       restart;
    logic [7:0] data;
  } qent_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       quota_filled;
  } res_t;

endpackage

/* rtl/ipv4_l4_payload_extractor.sv */
// An accepted byte that yields payload reaches the result side through the parser, the
// queue and the quota stage. Throughput: one byte per cycle while in_full is low.
// full rises only when the four-entry queue between parser and quota stage is
// full. Reset (rst_n low, synchronous) clears the parse state and collected
// count, empties both queues and sets the quota to 1024.
`timescale 1ns / 1ps

module ipv4_l4_payload_extractor #(
  parameter int MAX_QUOTA       = 65536,
  parameter int MIN_FRAME_BYTES = 54
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_op,
  input  logic [7:0]  in_frame_byte,
  input  logic [15:0] in_captured_length,
  input  logic        in_frame_end,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_payload_byte,
  output logic        out_quota_filled,
  input  logic        cfg_we,
  input  logic [16:0] cfg_payload_quota
);

  logic           accept;
  logic           mid_push, mid_pop, mid_full, mid_empty;
  lpe_pkg::qent_t mid_in, mid_out;
  logic [$bits(lpe_pkg::qent_t)-1:0] mid_raw;
  lpe_pkg::res_t  res;

  assign in_full = mid_full;
  assign accept  = in_push && !mid_full;

  lpe_front #(
    .MIN_FRAME_BYTES (MIN_FRAME_BYTES)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .op              (in_op),
    .frame_byte      (in_frame_byte),
    .captured_length (in_captured_length),
    .frame_end       (in_frame_end),
    .q_push          (mid_push),
    .q_data          (mid_in)
  );

  lpe_fifo #(
    .W     ($bits(lpe_pkg::qent_t)),
    .DEPTH (lpe_pkg::MID_DEPTH)
  ) u_mid_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_in),
    .pop   (mid_pop),
    .rdata (mid_raw),
    .full  (mid_full),
    .empty (mid_empty)
  );

  assign mid_out = lpe_pkg::qent_t'(mid_raw);

  lpe_back #(
    .MAX_QUOTA (MAX_QUOTA)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_payload_quota (cfg_payload_quota),
    .q_data            (mid_out),
    .q_empty           (mid_empty),
    .q_pop             (mid_pop),
    .res_pop           (out_pop),
    .res_data          (res),
    .res_empty         (out_empty)
  );

  assign out_payload_byte = res.payload_byte;
  assign out_quota_filled = res.quota_filled;

endmodule

/* rtl/lpe_fifo.sv */
// Small synchronous FIFO built from a register array with a fill count.
// Generic; no package dependencies.
`timescale 1ns / 1ps

module lpe_fifo #(
  parameter int W     = 9,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("fifo fill count above depth");

  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("fifo count did not grow on push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (empty || full) |-> (wr_ptr_r == rd_ptr_r))
    else $error("fifo pointers disagree with fill count");

endmodule

/* rtl/lpe_front.sv */
// Frame parser: tracks offsets and header fields, selects payload beats.
// Depends on lpe_pkg for protocol constants and the queue entry type.
`timescale 1ns / 1ps

module lpe_front #(
  parameter int MIN_FRAME_BYTES = 54
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic          op,
  input  logic [7:0]    frame_byte,
  input  logic [15:0]   captured_length,
  input  logic          frame_end,
  output logic          q_push,
  output lpe_pkg::qent_t q_data
);

  logic [15:0] offset_r, offset_nxt;
  logic [15:0] ekind_r, ekind_nxt;
  logic        vlan_r, vlan_nxt;
  logic [3:0]  ihl_r, ihl_nxt;
  logic [15:0] tlen_r, tlen_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [3:0]  doff_r, doff_nxt;
  logic        usable_r, usable_nxt;

  logic [15:0] rel;
  logic [5:0]  hdr_bytes;
  logic [3:0]  doff_eff;
  logic [6:0]  pay_start;
  logic        emit;
  logic        first;
  logic        is_l4;

  always_comb begin
    first = (offset_r == '0);
    // The first byte of a frame starts from a clean parse state.
    ekind_nxt  = first ? '0 : ekind_r;
    vlan_nxt   = first ? 1'b0 : vlan_r;
    ihl_nxt    = first ? '0 : ihl_r;
    tlen_nxt   = first ? '0 : tlen_r;
    proto_nxt  = first ? '0 : proto_r;
    doff_nxt   = first ? '0 : doff_r;
    usable_nxt = first ? (captured_length >= 16'(MIN_FRAME_BYTES)) : usable_r;
    offset_nxt = offset_r;
    emit       = 1'b0;
    rel        = '0;
    hdr_bytes  = '0;
    doff_eff   = '0;
    pay_start  = '0;
    is_l4      = 1'b0;

    if (offset_r == lpe_pkg::OFF_ETYPE_HI) begin
      ekind_nxt = {frame_byte, 8'h00};
    end else if (offset_r == lpe_pkg::OFF_ETYPE_LO) begin
      ekind_nxt = {ekind_r[15:8], frame_byte};
      if (ekind_nxt == lpe_pkg::ETH_TYPE_VLAN) begin
        vlan_nxt = 1'b1;
      end else if (ekind_nxt != lpe_pkg::ETH_TYPE_IPV4) begin
        usable_nxt = 1'b0;
      end
    end else if (vlan_r && offset_r == lpe_pkg::OFF_INNER_HI) begin
      ekind_nxt = {frame_byte, 8'h00};
    end else if (vlan_r && offset_r == lpe_pkg::OFF_INNER_LO) begin
      ekind_nxt = {ekind_r[15:8], frame_byte};
      if (ekind_nxt != lpe_pkg::ETH_TYPE_IPV4) begin
        usable_nxt = 1'b0;
      end
    end

    rel = offset_r - 16'(vlan_nxt ? lpe_pkg::IP_START_VLAN : lpe_pkg::IP_START_PLAIN);
    // Header length uses the value held before this byte.
    hdr_bytes = {ihl_nxt, 2'b00};

    if (usable_nxt && offset_r >= 16'(vlan_nxt ? lpe_pkg::IP_START_VLAN
                                               : lpe_pkg::IP_START_PLAIN)) begin
      if (rel == lpe_pkg::REL_VER_IHL) begin
        ihl_nxt = frame_byte[3:0];
        if (frame_byte[7:4] != lpe_pkg::IP_VERSION4 || frame_byte[3:0] < lpe_pkg::MIN_WORDS) begin
          usable_nxt = 1'b0;
        end
      end else if (rel == lpe_pkg::REL_TLEN_HI) begin
        tlen_nxt = {frame_byte, 8'h00};
      end else if (rel == lpe_pkg::REL_TLEN_LO) begin
        tlen_nxt = {tlen_r[15:8], frame_byte};
      end else if (rel == lpe_pkg::REL_PROTO) begin
        proto_nxt = frame_byte;
        if (frame_byte != lpe_pkg::PROTO_TCP && frame_byte != lpe_pkg::PROTO_UDP) begin
          usable_nxt = 1'b0;
        end
      end else if (proto_nxt == lpe_pkg::PROTO_TCP &&
                   rel == 16'(hdr_bytes) + lpe_pkg::REL_TCP_DOFF) begin
        doff_nxt = frame_byte[7:4];
        if (frame_byte[7:4] < lpe_pkg::MIN_WORDS) begin
          usable_nxt = 1'b0;
        end
      end

      doff_eff  = (doff_nxt < lpe_pkg::MIN_WORDS) ? lpe_pkg::MIN_WORDS : doff_nxt;
      pay_start = (proto_nxt == lpe_pkg::PROTO_TCP)
                ? 7'(hdr_bytes) + {1'b0, doff_eff, 2'b00}
                : 7'(hdr_bytes) + lpe_pkg::UDP_HDR_BYTES;
      is_l4 = (proto_nxt == lpe_pkg::PROTO_TCP) || (proto_nxt == lpe_pkg::PROTO_UDP);
      emit  = usable_nxt && (rel > lpe_pkg::REL_PROTO) && (hdr_bytes >= lpe_pkg::MIN_IP_HDR)
           && is_l4 && (rel >= 16'(pay_start)) && (rel < tlen_nxt);
    end

    offset_nxt = offset_r + 1'b1;
  end

  assign q_push = accept && ((op == lpe_pkg::OP_RESTART) ||
                             (offset_r != lpe_pkg::OFF_LAST && emit));
  assign q_data.restart = (op == lpe_pkg::OP_RESTART);
  assign q_data.data    = frame_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      ekind_r  <= '0;
      vlan_r   <= 1'b0;
      ihl_r    <= '0;
      tlen_r   <= '0;
      proto_r  <= '0;
      doff_r   <= '0;
      usable_r <= 1'b0;
    end else if (accept) begin
      if (op == lpe_pkg::OP_RESTART) begin
        offset_r <= '0;
      end else begin
        if (offset_r != lpe_pkg::OFF_LAST) begin
          offset_r <= offset_nxt;
          ekind_r  <= ekind_nxt;
          vlan_r   <= vlan_nxt;
          ihl_r    <= ihl_nxt;
          tlen_r   <= tlen_nxt;
          proto_r  <= proto_nxt;
          doff_r   <= doff_nxt;
          usable_r <= usable_nxt;
        end
        // A cleared offset makes the next byte reinitialize the parse state.
        if (frame_end) begin
          offset_r <= '0;
        end
      end
    end
  end

endmodule

/* rtl/lpe_back.sv */
// Quota stage: counts payload beats, flags the filling beat, buffers results.
// Depends on lpe_pkg and lpe_fifo.
`timescale 1ns / 1ps

module lpe_back #(
  parameter int MAX_QUOTA = 65536
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [16:0]    cfg_payload_quota,
  input  lpe_pkg::qent_t q_data,
  input  logic           q_empty,
  output logic           q_pop,
  input  logic           res_pop,
  output lpe_pkg::res_t  res_data,
  output logic           res_empty
);

  localparam int CW = $clog2(MAX_QUOTA + 1);
  localparam int QW = (CW > 17) ? CW : 17;

  logic [16:0]   quota_r;
  logic [QW-1:0] quota_ext, quota_sat;
  logic [CW-1:0] quota_eff;
  logic [CW-1:0] count_r, count_nxt;
  logic          res_full;
  logic          res_push;
  lpe_pkg::res_t res_in;
  logic [$bits(lpe_pkg::res_t)-1:0] res_raw;

  assign quota_ext = QW'(quota_r);
  assign quota_sat = (quota_ext > QW'(MAX_QUOTA)) ? QW'(MAX_QUOTA) : quota_ext;
  assign quota_eff = quota_sat[CW-1:0];

  // A restart never needs result space, so it drains even when results stall.
  assign q_pop = !q_empty && (q_data.restart || !res_full);

  always_comb begin
    count_nxt           = count_r;
    res_push            = 1'b0;
    res_in.payload_byte = q_data.data;
    res_in.quota_filled = 1'b0;
    if (q_pop) begin
      if (q_data.restart) begin
        count_nxt = '0;
      end else if (count_r < quota_eff) begin
        count_nxt           = count_r + 1'b1;
        res_push            = 1'b1;
        res_in.quota_filled = (count_nxt == quota_eff);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quota_r <= lpe_pkg::QUOTA_RESET;
      count_r <= '0;
    end else begin
      if (cfg_we) begin
        quota_r <= cfg_payload_quota;
      end
      count_r <= count_nxt;
    end
  end

  lpe_fifo #(
    .W     ($bits(lpe_pkg::res_t)),
    .DEPTH (lpe_pkg::OUT_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .pop   (res_pop),
    .rdata (res_raw),
    .full  (res_full),
    .empty (res_empty)
  );

  assign res_data = lpe_pkg::res_t'(res_raw);

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_data.restart) |=> (count_r == '0))
    else $error("restart did not clear the collected count");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> (count_r == '0 || count_r == $past(count_r) + 1'b1))
    else $error("collected count moved by more than one");

  a_push_space: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result beat pushed into a full buffer");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for ipv4_l4_payload_extractor: directed frame table, then random traffic.
// Depends on rtl/lpe_pkg.sv and rtl/ipv4_l4_payload_extractor.sv.
`timescale 1ns / 1ps

module tb_top;
  import lpe_pkg::*;

  localparam int MAX_QUOTA       = 65536;
  localparam int MIN_FRAME_BYTES = 54;
  localparam int SETTLE_CYCLES   = 16;
  localparam int HOLD_CYCLES     = 400;
  localparam int CYCLE_LIMIT     = 4000000;
  localparam int MAX_PRINTS      = 40;

  localparam logic [15:0] ETH_TYPE_IPV6 = 16'h86DD;
  localparam logic [7:0]  PROTO_ICMP    = 8'd1;

  // One directed or random frame; exp_n < 0 leaves the count to the predictor.
  typedef struct {
    bit          restart;
    logic [15:0] etype;
    logic [15:0] inner;
    logic [7:0]  ver_ihl;
    logic [7:0]  proto;
    logic [7:0]  doff;
    logic [15:0] tlen;
    logic [15:0] caplen;
    int          flen;
    bit          end_mark;
    int          fill;
    int          exp_n;
  } frame_spec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic        in_op = OP_BYTE;
  logic [7:0]  in_frame_byte = 8'h00;
  logic [15:0] in_captured_length = 16'h0000;
  logic        in_frame_end = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [7:0]  out_payload_byte;
  logic        out_quota_filled;
  logic        cfg_we = 1'b0;
  logic [16:0] cfg_payload_quota = QUOTA_RESET;

  ipv4_l4_payload_extractor #(
    .MAX_QUOTA      (MAX_QUOTA),
    .MIN_FRAME_BYTES(MIN_FRAME_BYTES)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_op             (in_op),
    .in_frame_byte     (in_frame_byte),
    .in_captured_length(in_captured_length),
    .in_frame_end      (in_frame_end),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_payload_byte  (out_payload_byte),
    .out_quota_filled  (out_quota_filled),
    .cfg_we            (cfg_we),
    .cfg_payload_quota (cfg_payload_quota)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  int cycle_count = 0;
  int fail_count = 0;
  int predicted_beats = 0;
  int beats_sent = 0;
  bit hold_results = 1'b0;

  res_t expected_payload[$];
  logic [7:0] frame_bytes[$];
  frame_spec_t directed_rows[$];

  // Predictor state.
  logic [15:0] fr_pos;
  logic [15:0] fr_etype;
  logic [4:0]  fr_ip_start;
  logic [3:0]  fr_ihl;
  logic [15:0] fr_tlen;
  logic [7:0]  fr_proto;
  logic [3:0]  fr_doff;
  logic        fr_ok;
  logic [16:0] got_count;
  logic [16:0] quota_reg;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report(input string what);
    fail_count++;
    if (fail_count <= MAX_PRINTS) $display("ERROR cycle %0d: %s", cycle_count, what);
  endtask

  function automatic void forget_frame();
    fr_pos = '0;
    fr_etype = '0;
    fr_ip_start = IP_START_PLAIN;
    fr_ihl = '0;
    fr_tlen = '0;
    fr_proto = '0;
    fr_doff = '0;
    fr_ok = 1'b0;
  endfunction

  // Works out the payload beat, if any, that one accepted input beat yields.
  function automatic bit extract_step(input logic op, input logic [7:0] b,
                                      input logic [15:0] caplen, input logic last,
                                      output res_t r);
    logic [15:0] o;
    logic [15:0] rel;
    logic [6:0]  t;
    logic [6:0]  p;
    logic [3:0]  dw;
    logic [16:0] cap_q;
    bit          hit;
    hit = 1'b0;
    r = '0;
    o = fr_pos;
    if (op == OP_RESTART) begin
      forget_frame();
      got_count = '0;
      return 1'b0;
    end
    if (o < OFF_LAST) begin
      if (o == 16'd0) begin
        forget_frame();
        fr_ok = caplen >= MIN_FRAME_BYTES;
      end
      if (o == OFF_ETYPE_HI) begin
        fr_etype = {b, 8'h00};
      end else if (o == OFF_ETYPE_LO) begin
        fr_etype = fr_etype | {8'h00, b};
        if (fr_etype == ETH_TYPE_VLAN) fr_ip_start = IP_START_VLAN;
        else if (fr_etype != ETH_TYPE_IPV4) fr_ok = 1'b0;
      end else if (fr_ip_start == IP_START_VLAN && o == OFF_INNER_HI) begin
        fr_etype = {b, 8'h00};
      end else if (fr_ip_start == IP_START_VLAN && o == OFF_INNER_LO) begin
        fr_etype = fr_etype | {8'h00, b};
        if (fr_etype != ETH_TYPE_IPV4) fr_ok = 1'b0;
      end

      if (fr_ok && o >= IP_START_PLAIN && o >= fr_ip_start) begin
        rel = o - {11'd0, fr_ip_start};
        t = {1'b0, fr_ihl, 2'b00};
        if (rel == REL_VER_IHL) begin
          fr_ihl = b[3:0];
          if (b[7:4] != IP_VERSION4 || fr_ihl < MIN_WORDS) fr_ok = 1'b0;
        end else if (rel == REL_TLEN_HI) begin
          fr_tlen = {b, 8'h00};
        end else if (rel == REL_TLEN_LO) begin
          fr_tlen = fr_tlen | {8'h00, b};
        end else if (rel == REL_PROTO) begin
          fr_proto = b;
          if (b != PROTO_TCP && b != PROTO_UDP) fr_ok = 1'b0;
        end else if (fr_proto == PROTO_TCP && rel == {9'd0, t} + REL_TCP_DOFF) begin
          fr_doff = b[7:4];
          if (fr_doff < MIN_WORDS) fr_ok = 1'b0;
        end

        if (fr_proto == PROTO_TCP) begin
          dw = (fr_doff < MIN_WORDS) ? MIN_WORDS : fr_doff;
          p = t + {1'b0, dw, 2'b00};
        end else begin
          p = t + UDP_HDR_BYTES;
        end

        cap_q = (quota_reg > MAX_QUOTA) ? 17'(MAX_QUOTA) : quota_reg;

        if (fr_ok && rel > REL_PROTO && t >= MIN_IP_HDR &&
            (fr_proto == PROTO_TCP || fr_proto == PROTO_UDP) &&
            rel >= {9'd0, p} && rel < fr_tlen && got_count < cap_q) begin
          got_count = got_count + 17'd1;
          r.payload_byte = b;
          r.quota_filled = (got_count == cap_q);
          hit = 1'b1;
        end
      end
      fr_pos = o + 16'd1;
    end
    if (last) forget_frame();
    return hit;
  endfunction

  // Offers one input beat, waits until it is taken, then predicts its result.
  task automatic send_beat(input logic op, input logic [7:0] b, input logic [15:0] len,
                           input logic last, input bit no_gap);
    int   gap;
    res_t r;
    gap = no_gap ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_op <= op;
    in_frame_byte <= b;
    in_captured_length <= len;
    in_frame_end <= last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    beats_sent++;
    if (extract_step(op, b, len, last, r)) begin
      expected_payload.push_back(r);
      predicted_beats++;
    end
  endtask

  function automatic void put_byte(input int idx, input logic [7:0] v);
    if (idx < frame_bytes.size()) frame_bytes[idx] = v;
  endfunction

  task automatic send_event(input frame_spec_t s, input bit no_idle);
    int ipst;
    int l4;
    if (s.restart) begin
      send_beat(OP_RESTART, $urandom, $urandom, $urandom, no_idle);
      return;
    end
    frame_bytes.delete();
    for (int i = 0; i < s.flen; i++)
      frame_bytes.push_back((s.fill < 0) ? 8'($urandom) : 8'(s.fill));
    ipst = (s.etype == ETH_TYPE_VLAN) ? IP_START_VLAN : IP_START_PLAIN;
    put_byte(OFF_ETYPE_HI, s.etype[15:8]);
    put_byte(OFF_ETYPE_LO, s.etype[7:0]);
    if (s.etype == ETH_TYPE_VLAN) begin
      put_byte(OFF_INNER_HI, s.inner[15:8]);
      put_byte(OFF_INNER_LO, s.inner[7:0]);
    end
    put_byte(ipst + REL_VER_IHL, s.ver_ihl);
    put_byte(ipst + REL_TLEN_HI, s.tlen[15:8]);
    put_byte(ipst + REL_TLEN_LO, s.tlen[7:0]);
    put_byte(ipst + REL_PROTO, s.proto);
    l4 = ipst + 4 * s.ver_ihl[3:0];
    if (s.proto == PROTO_TCP) put_byte(l4 + REL_TCP_DOFF, s.doff);
    foreach (frame_bytes[i])
      send_beat(OP_BYTE, frame_bytes[i], s.caplen,
                s.end_mark && (i == frame_bytes.size() - 1), no_idle);
  endtask

  function automatic frame_spec_t frame_row(input bit restart, input logic [15:0] etype,
                                            input logic [15:0] inner, input logic [7:0] ver_ihl,
                                            input logic [7:0] proto, input logic [7:0] doff,
                                            input logic [15:0] tlen, input logic [15:0] caplen,
                                            input int flen, input bit end_mark, input int fill,
                                            input int exp_n);
    frame_spec_t s;
    s.restart = restart;
    s.etype = etype;
    s.inner = inner;
    s.ver_ihl = ver_ihl;
    s.proto = proto;
    s.doff = doff;
    s.tlen = tlen;
    s.caplen = caplen;
    s.flen = flen;
    s.end_mark = end_mark;
    s.fill = fill;
    s.exp_n = exp_n;
    return s;
  endfunction

  // Mostly well-formed frames with random content; clean ones always carry payload.
  function automatic frame_spec_t random_spec(input bit clean, input bit broken);
    frame_spec_t s;
    int ihl;
    int dw;
    int hdr;
    int paylen;
    int ipst;
    s.restart = 1'b0;
    s.exp_n = -1;
    s.fill = -1;
    s.end_mark = 1'b1;
    s.etype = ($urandom_range(0, 2) == 0) ? ETH_TYPE_VLAN : ETH_TYPE_IPV4;
    s.inner = ETH_TYPE_IPV4;
    ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
    s.ver_ihl = {IP_VERSION4, 4'(ihl)};
    s.proto = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
    dw = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
    s.doff = {4'(dw), 4'($urandom)};
    hdr = 4 * ihl + ((s.proto == PROTO_TCP) ? 4 * dw : UDP_HDR_BYTES);
    paylen = clean ? $urandom_range(16, 40) : $urandom_range(0, 24);
    s.tlen = 16'(hdr + paylen);
    ipst = (s.etype == ETH_TYPE_VLAN) ? IP_START_VLAN : IP_START_PLAIN;
    s.flen = ipst + hdr + paylen + $urandom_range(0, 6);
    s.caplen = (s.flen < MIN_FRAME_BYTES) ? 16'(MIN_FRAME_BYTES + $urandom_range(0, 40))
                                          : 16'(s.flen);
    if (!clean) begin
      if ($urandom_range(0, 7) == 0) s.caplen = $urandom;
      if ($urandom_range(0, 7) == 0) s.flen = $urandom_range(20, s.flen);
      if ($urandom_range(0, 19) == 0) s.end_mark = 1'b0;
      if ($urandom_range(0, 9) == 0) s.fill = $urandom_range(0, 1) ? 255 : 0;
      if (broken) begin
        case ($urandom_range(0, 6))
          0: s.etype = $urandom;
          1: begin
            s.etype = ETH_TYPE_VLAN;
            s.inner = $urandom;
          end
          2: s.ver_ihl[7:4] = $urandom;
          3: s.ver_ihl[3:0] = $urandom_range(0, 4);
          4: s.proto = $urandom;
          5: begin
            s.proto = PROTO_TCP;
            s.doff[7:4] = $urandom_range(0, 4);
          end
          default: s.tlen = $urandom_range(0, hdr);
        endcase
      end
    end
    return s;
  endfunction

  task automatic random_event(input bit eager);
    int sel;
    int n;
    bit no_idle;
    sel = $urandom_range(0, 99);
    no_idle = eager || ($urandom_range(0, 4) == 0);
    if (sel < 4) begin
      send_beat(OP_RESTART, $urandom, $urandom, $urandom, no_idle);
    end else if (sel < 12) begin
      n = $urandom_range(1, 60);
      repeat (n) send_beat(OP_BYTE, $urandom, $urandom, $urandom_range(0, 15) == 0, no_idle);
    end else begin
      send_event(random_spec(1'b0, sel < 30), no_idle);
    end
  endtask

  // Waits for every expected beat, then lets in-flight beats that yield nothing drain.
  task automatic wait_drained();
    in_push <= 1'b0;
    while (expected_payload.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_quota(input logic [16:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_payload_quota <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    quota_reg = v;
  endtask

  task automatic run_traffic(input logic [16:0] quota, input int budget, input bit hold,
                             input bit eager);
    int start;
    set_quota(quota);
    start = beats_sent;
    if (hold) begin
      hold_results = 1'b1;
      send_event(random_spec(1'b1, 1'b0), 1'b1);
    end
    while (beats_sent - start < budget) random_event(eager);
  endtask

  // Result side: draws a pop delay per beat and compares against the oldest prediction.
  initial begin
    int   gap;
    int   fast_run;
    res_t e;
    fast_run = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_results) begin
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end
      if (fast_run > 0) begin
        gap = 0;
        fast_run--;
      end else if ($urandom_range(0, 7) == 0) begin
        gap = 0;
        fast_run = 24;
      end else begin
        gap = $urandom_range(0, 4);
      end
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
      if (expected_payload.size() == 0) begin
        report($sformatf("unexpected beat: byte %02h quota_filled %b",
                         out_payload_byte, out_quota_filled));
      end else begin
        e = expected_payload.pop_front();
        if (out_payload_byte !== e.payload_byte)
          report($sformatf("payload_byte %02h, predicted %02h", out_payload_byte,
                           e.payload_byte));
        if (out_quota_filled !== e.quota_filled)
          report($sformatf("quota_filled %b, predicted %b (byte %02h)", out_quota_filled,
                           e.quota_filled, e.payload_byte));
      end
    end
  end

  initial begin
    int count_mark;
    frame_spec_t s;

    quota_reg = QUOTA_RESET;
    got_count = '0;
    forget_frame();

    // Args: restart, etype, inner, ver_ihl, proto, doff, tlen, caplen, flen, end, fill, count.
    directed_rows.push_back(frame_row(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, -1, 0));
    directed_rows.push_back(frame_row(0, ETH_TYPE_IPV4, 0, 8'h45, PROTO_TCP, 8'h50,
                                      50, 64, 64, 1, -1, 10));
    directed_rows.push_back(frame_row(0, ETH_TYPE_IPV4, 0, 8'h45, PROTO_UDP, 8'h00,
                                      34, 54, 54, 1, -1, 6));
    // Captured length one below the minimum, then zero.
    directed_rows.push_back(frame_row(0, ETH_TYPE_IPV4, 0, 8'h45, PROTO_UDP, 8'h00,
                                      34, 53, 54, 1, -1, 0));
    directed_rows.push_back(frame_row(0, ETH_TYPE_IPV4, 0, 8'h45, PROTO_UDP, 8'h00,
                                      34, 0, 54, 1, -1, 0));
    directed_rows.push_back(frame_row(0, ETH_TYPE_IPV4, 0, 8'h45, PROTO_UDP, 8'h00,
                                      34, 16'hFFFF, 60, 1, 255, 6));
    directed_rows.push_back(frame_row(0, ETH_TYPE_IPV4, 0, 8'h45, PROTO_TCP, 8'h50,
                                      50, 64, 64, 1, 0, 10));
    directed_rows.push_back(frame_row(0, ETH_TYPE_VLAN, ETH_TYPE_IPV4, 8'h45, PROTO_TCP, 8'h50,
                                      45, 63, 63, 1, -1, 5));
    directed_rows.push_back(frame_row(0, ETH_TYPE_VLAN, ETH_TYPE_IPV6, 8'h45, PROTO_TCP, 8'h50,
                                      45, 63, 63, 1, -1, 0));
    directed_rows.push_back(frame_row(0, ETH_TYPE_IPV6, 0, 8'h45, PROTO_TCP, 8'h50,
                                      50, 64, 64, 1, -1, 0));
    directed_rows.push_back(frame_row(0, ETH_TYPE_IPV4, 0, 8'h65, PROTO_TCP, 8'h50,
                                      50, 64, 64, 1, -1, 0));
    directed_rows.push_back(frame_row(0, ETH_TYPE_IPV4, 0, 8'h44, PROTO_TCP, 8'h50,
                                      50, 64, 64, 1, -1, 0));
    // Largest IP and TCP headers.
    directed_rows.push_back(frame_row(0, ETH_TYPE_IPV4, 0, 8'h4F, PROTO_TCP, 8'hF0,
                                      125, 139, 139, 1, -1, 5));
    directed_rows.push_back(frame_row(0, ETH_TYPE_IPV4, 0, 8'h45, PROTO_ICMP, 8'h50,
                                      50, 64, 64, 1, -1, 0));
    directed_rows.push_back(frame_row(0, ETH_TYPE_IPV4, 0, 8'h45, PROTO_TCP, 8'h4F,
                                      50, 64, 64, 1, -1, 0));
    // Total length that ends inside the headers.
    directed_rows.push_back(frame_row(0, ETH_TYPE_IPV4, 0, 8'h45, PROTO_TCP, 8'h50,
                                      30, 64, 64, 1, -1, 0));
    directed_rows.push_back(frame_row(0, ETH_TYPE_IPV4, 0, 8'h45, PROTO_TCP, 8'h50,
                                      0, 64, 64, 1, -1, 0));
    // Delivered bytes stop before the total length does.
    directed_rows.push_back(frame_row(0, ETH_TYPE_IPV4, 0, 8'h45, PROTO_TCP, 8'h50,
                                      100, 200, 60, 1, -1, 6));
    // A frame without an end marker runs into the next one.
    directed_rows.push_back(frame_row(0, ETH_TYPE_IPV4, 0, 8'h45, PROTO_UDP, 8'h00,
                                      34, 54, 54, 0, -1, 6));
    directed_rows.push_back(frame_row(0, ETH_TYPE_IPV4, 0, 8'h45, PROTO_TCP, 8'h50,
                                      50, 64, 64, 1, -1, -1));
    // Restart in the middle of a frame clears its parse state.
    directed_rows.push_back(frame_row(0, ETH_TYPE_IPV4, 0, 8'h45, PROTO_TCP, 8'h50,
                                      50, 64, 48, 0, -1, 0));
    directed_rows.push_back(frame_row(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, -1, 0));
    directed_rows.push_back(frame_row(0, ETH_TYPE_IPV4, 0, 8'h45, PROTO_TCP, 8'h50,
                                      50, 64, 64, 1, -1, 10));
    directed_rows.push_back(frame_row(0, ETH_TYPE_VLAN, ETH_TYPE_IPV4, 8'h45, PROTO_UDP, 8'h00,
                                      16'hFFFF, 120, 120, 1, -1, -1));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part runs at the reset quota.
    foreach (directed_rows[i]) begin
      count_mark = predicted_beats;
      send_event(directed_rows[i], $urandom_range(0, 1));
      if (directed_rows[i].exp_n >= 0 && predicted_beats - count_mark != directed_rows[i].exp_n)
        report($sformatf("row %0d: predictor gives %0d payload beats, table says %0d",
                         i, predicted_beats - count_mark, directed_rows[i].exp_n));
    end

    run_traffic(17'd1, 290, 1'b0, 1'b0);
    run_traffic(17'd9, 290, 1'b0, 1'b0);
    run_traffic(17'd0, 290, 1'b0, 1'b0);
    run_traffic(17'd65536, 290, 1'b1, 1'b1);
    run_traffic(17'd50, 290, 1'b0, 1'b0);
    run_traffic(17'($urandom_range(2, 300)), 290, 1'b0, 1'b0);

    // An oversized quota saturates; one frame past the offset limit nearly fills it,
    // and the following frames fill it and then get nothing.
    set_quota(17'h1FFFF);
    send_beat(OP_RESTART, $urandom, $urandom, $urandom, 1'b0);
    s = frame_row(0, ETH_TYPE_IPV4, 0, 8'h45, PROTO_UDP, 8'h00,
                  16'hFFFF, 16'hFFFF, 65540, 1, -1, -1);
    send_event(s, 1'b0);
    repeat (6) send_event(random_spec(1'b1, 1'b0), $urandom_range(0, 1));

    wait_drained();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/lpe_pkg.sv
rtl/lpe_fifo.sv
rtl/lpe_front.sv
rtl/lpe_back.sv
rtl/ipv4_l4_payload_extractor.sv
tb/tb_top.sv
